// ===== rtl/tsst_pkg.sv =====
`timescale 1ns / 1ps

package tsst_pkg;

    // Table geometry
    localparam int SLOT_COUNT      = 64;
    localparam int SLOT_IDX_W      = $clog2(SLOT_COUNT);
    // Tick count per slot, a power of two
    localparam int SLOT_TICKS_LOG2 = 10;
    localparam int SLOT_TICKS      = 1 << SLOT_TICKS_LOG2;

    // Field widths
    localparam int OP_W      = 2;
    localparam int OWNER_W   = 8;
    localparam int LEN_W     = 8;
    localparam int END_W     = 9;
    localparam int SLOT_FW   = 7;
    localparam int TIME_W    = 64;
    localparam int SLOT_NUM_W = TIME_W - SLOT_TICKS_LOG2;

    localparam logic [LEN_W-1:0] LEN_MAX = 8'hFF;

    // Opcodes
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [LEN_W-1:0]   len;
    } t_slot_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic respond;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic range_empty;
        logic last_step;
    } t_dp_status;

endpackage

// ===== rtl/tsst_ctrl.sv =====
`timescale 1ns / 1ps

module tsst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [tsst_pkg::OP_W-1:0]   i_opcode,
    input  tsst_pkg::t_dp_status        i_status,
    output tsst_pkg::t_dp_cmd           o_cmd,
    output logic                        busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       is_range_op;

    assign is_range_op = (i_opcode == tsst_pkg::OP_UPDATE) ||
                         (i_opcode == tsst_pkg::OP_DELETE);
    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (is_range_op && !i_status.range_empty) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.last_step) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/tsst_datapath.sv =====
`timescale 1ns / 1ps

module tsst_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsst_pkg::t_dp_cmd                i_cmd,
    output tsst_pkg::t_dp_status             o_status,
    input  logic [tsst_pkg::OP_W-1:0]        i_opcode,
    input  logic [tsst_pkg::OWNER_W-1:0]     i_owner_id,
    input  logic [tsst_pkg::END_W-1:0]       i_end_slot,
    input  logic [tsst_pkg::SLOT_FW-1:0]     i_first_slot,
    input  logic [tsst_pkg::SLOT_FW-1:0]     i_stop_slot,
    input  logic [tsst_pkg::TIME_W-1:0]      i_now_time,
    output logic                             o_valid,
    output logic                             o_scheduled,
    output logic [tsst_pkg::OWNER_W-1:0]     o_chosen_owner,
    output logic [tsst_pkg::TIME_W-1:0]      o_slice_timeout
);

    // Slot table and per-entry written flags
    tsst_pkg::t_slot_entry r_mem [tsst_pkg::SLOT_COUNT];
    logic [tsst_pkg::SLOT_COUNT-1:0] r_written;

    // Latched command
    logic                              r_clear;
    logic                              r_is_fetch;
    logic [tsst_pkg::OWNER_W-1:0]      r_owner;
    logic [tsst_pkg::END_W-1:0]        r_end;
    logic [tsst_pkg::SLOT_FW-1:0]      r_cnt;
    logic [tsst_pkg::SLOT_FW-1:0]      r_lim;
    logic [tsst_pkg::SLOT_NUM_W-1:0]   r_slot;
    tsst_pkg::t_slot_entry             r_rd_data;
    logic                              r_rd_written;

    // Result registers
    logic                              r_valid;
    logic                              r_scheduled;
    logic [tsst_pkg::OWNER_W-1:0]      r_chosen_owner;
    logic [tsst_pkg::TIME_W-1:0]       r_slice_timeout;

    logic [tsst_pkg::SLOT_FW-1:0]      lim_in;
    logic [tsst_pkg::SLOT_FW-1:0]      n_cnt;
    logic [tsst_pkg::SLOT_IDX_W-1:0]   wr_idx;
    logic [tsst_pkg::SLOT_IDX_W-1:0]   rd_idx;
    logic [tsst_pkg::END_W-1:0]        diff;
    tsst_pkg::t_slot_entry             wr_entry;
    logic [tsst_pkg::LEN_W-1:0]        len_eff;
    logic [tsst_pkg::SLOT_NUM_W-1:0]   end_slot_num;

    // Clip the range to the table
    assign lim_in = (i_stop_slot > tsst_pkg::SLOT_FW'(tsst_pkg::SLOT_COUNT)) ?
                    tsst_pkg::SLOT_FW'(tsst_pkg::SLOT_COUNT) : i_stop_slot;
    assign n_cnt  = r_cnt + tsst_pkg::SLOT_FW'(1);
    assign o_status.range_empty = (i_first_slot >= lim_in);
    assign o_status.last_step   = (n_cnt >= r_lim);

    assign wr_idx = r_cnt[tsst_pkg::SLOT_IDX_W-1:0];
    assign rd_idx = i_now_time[tsst_pkg::SLOT_TICKS_LOG2 +: tsst_pkg::SLOT_IDX_W];
    assign diff   = r_end - tsst_pkg::END_W'(wr_idx);

    always_comb begin
        if (r_clear) begin
            wr_entry = '0;
        end else begin
            wr_entry.owner = r_owner;
            if (r_end < tsst_pkg::END_W'(wr_idx)) begin
                wr_entry.len = '0;
            end else if (diff > tsst_pkg::END_W'(tsst_pkg::LEN_MAX)) begin
                wr_entry.len = tsst_pkg::LEN_MAX;
            end else begin
                wr_entry.len = diff[tsst_pkg::LEN_W-1:0];
            end
        end
    end

    // Unwritten entries read as the reset length
    assign len_eff = r_rd_written ? r_rd_data.len :
                     (tsst_pkg::LEN_W'(tsst_pkg::SLOT_COUNT) -
                      tsst_pkg::LEN_W'(r_slot[tsst_pkg::SLOT_IDX_W-1:0]));
    assign end_slot_num = r_slot + tsst_pkg::SLOT_NUM_W'(len_eff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_mem[wr_idx] <= wr_entry;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.walk) begin
            r_written[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clear      <= (i_opcode == tsst_pkg::OP_DELETE);
            r_is_fetch   <= (i_opcode == tsst_pkg::OP_FETCH);
            r_owner      <= i_owner_id;
            r_end        <= i_end_slot;
            r_cnt        <= i_first_slot;
            r_lim        <= lim_in;
            r_slot       <= i_now_time[tsst_pkg::TIME_W-1:tsst_pkg::SLOT_TICKS_LOG2];
            r_rd_written <= r_written[rd_idx];
        end else if (i_cmd.walk) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            if (r_is_fetch && (len_eff != '0)) begin
                r_scheduled     <= 1'b1;
                r_chosen_owner  <= r_rd_written ? r_rd_data.owner : '0;
                r_slice_timeout <= {end_slot_num, {tsst_pkg::SLOT_TICKS_LOG2{1'b0}}};
            end else begin
                r_scheduled     <= 1'b0;
                r_chosen_owner  <= '0;
                r_slice_timeout <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_scheduled     = r_scheduled;
    assign o_chosen_owner  = r_chosen_owner;
    assign o_slice_timeout = r_slice_timeout;

endmodule

// ===== rtl/time_slot_schedule_table_unit.sv =====
`timescale 1ns / 1ps
// A fetch, a no-op or an empty range goes from idle straight to the respond state; the
// result strobe is registered from the respond state. An update or delete over n slots walks
// its range first, one slot a cycle. The next beat is taken in the cycle the result strobe is
// high, so a new beat is not taken before the last result is out.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: synchronous, active low; the table reads as its reset content at once, no clear pass.

module time_slot_schedule_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tsst_pkg::OP_W-1:0]        i_opcode,
    input  logic [tsst_pkg::OWNER_W-1:0]     i_owner_id,
    input  logic [tsst_pkg::END_W-1:0]       i_end_slot,
    input  logic [tsst_pkg::SLOT_FW-1:0]     i_first_slot,
    input  logic [tsst_pkg::SLOT_FW-1:0]     i_stop_slot,
    input  logic [tsst_pkg::TIME_W-1:0]      i_now_time,
    output logic                             o_valid,
    output logic                             o_scheduled,
    output logic [tsst_pkg::OWNER_W-1:0]     o_chosen_owner,
    output logic [tsst_pkg::TIME_W-1:0]      o_slice_timeout
);

    // Command and status between the sequencer and the table datapath
    tsst_pkg::t_dp_cmd    dp_cmd;
    tsst_pkg::t_dp_status dp_status;

    // Sequencer: take a beat when idle, walk the range one slot a cycle, then respond.
    tsst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .busy     (busy)
    );

    // Datapath: slot table memory, written flags, range counter and result registers.
    // A fetch reads the table in the accept cycle; the timeout is formed in the respond cycle.
    tsst_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_opcode        (i_opcode),
        .i_owner_id      (i_owner_id),
        .i_end_slot      (i_end_slot),
        .i_first_slot    (i_first_slot),
        .i_stop_slot     (i_stop_slot),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .o_scheduled     (o_scheduled),
        .o_chosen_owner  (o_chosen_owner),
        .o_slice_timeout (o_slice_timeout)
    );

endmodule

// ===== rtl/tsst_checker.sv =====
`timescale 1ns / 1ps

module tsst_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic [tsst_pkg::OP_W-1:0]        i_opcode,
    input logic                             o_valid,
    input logic                             o_scheduled,
    input logic [tsst_pkg::OWNER_W-1:0]     o_chosen_owner,
    input logic [tsst_pkg::TIME_W-1:0]      o_slice_timeout
);

    // A result only appears once the unit is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A fetch beat passes through the busy respond state before its result strobe
    a_fetch_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == tsst_pkg::OP_FETCH)) |=> busy ##1 o_valid)
        else $error("fetch result late or missing");

    // Unscheduled results carry zero owner and timeout
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_scheduled) |-> ((o_chosen_owner == '0) && (o_slice_timeout == '0)))
        else $error("unscheduled result not zero");

    // One strobe per beat
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind time_slot_schedule_table_unit tsst_checker u_tsst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_opcode        (i_opcode),
    .o_valid         (o_valid),
    .o_scheduled     (o_scheduled),
    .o_chosen_owner  (o_chosen_owner),
    .o_slice_timeout (o_slice_timeout)
);
